// ===== hdl/deqpm_pkg.sv =====
// Shared types and constants for the double-ended queue with pop-maximum.
`timescale 1ns / 1ps

package deqpm_pkg;

    localparam int DATA_W       = 32;
    localparam int CMD_W        = 3;
    localparam int STATUS_W     = 2;
    localparam int OCC_W        = 5;
    localparam int CAPACITY_DEF = 16;
    localparam int S_TDATA_W    = 40;
    localparam int M_TDATA_W    = 104;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_BACK   = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_POP_MAX    = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE  = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        OP_KEEP,
        OP_LOAD,
        OP_FROM_LEFT,
        OP_FROM_RIGHT
    } cell_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_REMOVE,
        ST_REPORT
    } state_t;

    typedef struct packed {
        cell_op_t op;
        logic     occupied;
    } cell_ctrl_t;

    typedef struct packed {
        logic                     vld;
        logic signed [DATA_W-1:0] value;
    } scan_t;

endpackage

// ===== hdl/deqpm_cell.sv =====
// One storage cell of the queue chain with its stage of the running-maximum scan.
`timescale 1ns / 1ps

module deqpm_cell #(
    parameter int IDX_W    = 4,
    parameter int CELL_IDX = 0
) (
    input  logic                                  clk,
    input  deqpm_pkg::cell_ctrl_t                 ctrl,
    input  logic signed [deqpm_pkg::DATA_W-1:0]   push_value,
    input  logic signed [deqpm_pkg::DATA_W-1:0]   left_value,
    input  logic signed [deqpm_pkg::DATA_W-1:0]   right_value,
    input  deqpm_pkg::scan_t                      scan_in,
    input  logic [IDX_W-1:0]                      scan_in_idx,
    output logic signed [deqpm_pkg::DATA_W-1:0]   value,
    output deqpm_pkg::scan_t                      scan_out,
    output logic [IDX_W-1:0]                      scan_out_idx
);

    logic signed [deqpm_pkg::DATA_W-1:0] value_reg, value_next;
    deqpm_pkg::scan_t                    scan_reg, scan_next;
    logic [IDX_W-1:0]                    idx_reg, idx_next;
    logic                                take_own;

    always_comb
    begin
        case (ctrl.op)
            deqpm_pkg::OP_LOAD:       value_next = push_value;
            deqpm_pkg::OP_FROM_LEFT:  value_next = left_value;
            deqpm_pkg::OP_FROM_RIGHT: value_next = right_value;
            default:                  value_next = value_reg;
        endcase
    end

    // Strict compare keeps the earlier element on a tie.
    assign take_own = ctrl.occupied && (!scan_in.vld || (value_reg > scan_in.value));

    always_comb
    begin
        if (take_own)
        begin
            scan_next.vld   = 1'b1;
            scan_next.value = value_reg;
            idx_next        = IDX_W'(CELL_IDX);
        end
        else
        begin
            scan_next = scan_in;
            idx_next  = scan_in_idx;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        scan_reg  <= scan_next;
        idx_reg   <= idx_next;
    end

    assign value        = value_reg;
    assign scan_out     = scan_reg;
    assign scan_out_idx = idx_reg;

endmodule

// ===== hdl/double_ended_queue_with_pop_max.sv =====
// Top level of the bounded double-ended queue with pop-maximum over a chain of cells.
`timescale 1ns / 1ps

// Channel   Direction  Ports                           Contents
// s_axis    in         s_tvalid, s_tready, s_tdata     one command
// m_axis    out        m_tvalid, m_tready, m_tdata     one result per command
//
// Pushes, end pops and unused codes pass through the execute and report states
// after their transfer. Pop maximum also passes through the scan and remove
// states, with the running maximum walking down the cell chain one cell per cycle.
// Reset clears the state machine, the element count and the output valid flag;
// stored elements are not cleared. A new command is taken only when the
// previous result has been loaded into the output register, so a stalled
// output holds off the next command only while a result waits to be loaded.

module double_ended_queue_with_pop_max #(
    parameter int CAPACITY = deqpm_pkg::CAPACITY_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // Fields from bit 0: cmd[2:0], push_value[34:3], zero padding[39:35].
    input  logic [deqpm_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // Fields from bit 0: status[1:0], popped_value[33:2], is_empty[34],
    // front_value[66:35], back_value[98:67], occupancy[103:99].
    output logic [deqpm_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int DW = deqpm_pkg::DATA_W;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    // Cell i always holds the element at logical position i; position 0 is the front.
    deqpm_pkg::state_t       state_reg, state_next;
    logic [deqpm_pkg::CMD_W-1:0] cmd_reg;
    logic signed [DW-1:0]    val_reg;
    logic [CW-1:0]           count_reg, count_next;
    logic [IW-1:0]           scan_cnt_reg, scan_cnt_next;
    logic [IW-1:0]           best_reg, best_next;
    logic signed [DW-1:0]    popped_reg, popped_next;
    deqpm_pkg::status_t      status_reg, status_next;
    logic                    m_tvalid_reg;
    logic [deqpm_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic                    load_out;

    deqpm_pkg::cell_op_t     cell_op   [CAPACITY];
    deqpm_pkg::cell_ctrl_t   cell_ctrl [CAPACITY];
    logic signed [DW-1:0]    cell_val  [CAPACITY];
    deqpm_pkg::scan_t        scan_bus  [CAPACITY];
    logic [IW-1:0]           idx_bus   [CAPACITY];

    logic signed [DW-1:0]    front_val, back_val;
    logic                    is_full, is_empty_now;
    logic [31:0]             occ_wide;

    // The cell chain. Each cell shifts toward either neighbor and passes the
    // running maximum of everything in front of it to the cell behind it.
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic signed [DW-1:0] left_v, right_v;
        deqpm_pkg::scan_t     s_in;
        logic [IW-1:0]        s_in_idx;

        if (g == 0)
        begin : g_first
            assign left_v   = '0;
            assign s_in     = '0;
            assign s_in_idx = '0;
        end
        else
        begin : g_mid
            assign left_v   = cell_val[g-1];
            assign s_in     = scan_bus[g-1];
            assign s_in_idx = idx_bus[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_v = '0;
        end
        else
        begin : g_inner
            assign right_v = cell_val[g+1];
        end

        assign cell_ctrl[g].op       = cell_op[g];
        assign cell_ctrl[g].occupied = (CW'(g) < count_reg);

        deqpm_cell #(
            .IDX_W    (IW),
            .CELL_IDX (g)
        ) u_cell (
            .clk          (clk),
            .ctrl         (cell_ctrl[g]),
            .push_value   (val_reg),
            .left_value   (left_v),
            .right_value  (right_v),
            .scan_in      (s_in),
            .scan_in_idx  (s_in_idx),
            .value        (cell_val[g]),
            .scan_out     (scan_bus[g]),
            .scan_out_idx (idx_bus[g])
        );
    end

    assign is_full      = (count_reg == CW'(CAPACITY));
    assign is_empty_now = (count_reg == '0);
    assign front_val    = is_empty_now ? '0 : cell_val[0];

    // The back element sits in the cell whose position is count - 1.
    always_comb
    begin
        back_val = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (!is_empty_now && (CW'(i) == count_reg - CW'(1)))
            begin
                back_val = back_val | cell_val[i];
            end
        end
    end

    assign s_tready = (state_reg == deqpm_pkg::ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        scan_cnt_next = scan_cnt_reg;
        best_next     = best_reg;
        popped_next   = popped_reg;
        status_next   = status_reg;
        load_out      = 1'b0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_op[i] = deqpm_pkg::OP_KEEP;
        end

        case (state_reg)
            deqpm_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = deqpm_pkg::ST_EXEC;
                end
            end

            deqpm_pkg::ST_EXEC:
            begin
                status_next = deqpm_pkg::STAT_DONE;
                popped_next = '0;
                state_next  = deqpm_pkg::ST_REPORT;
                case (cmd_reg)
                    deqpm_pkg::CMD_PUSH_BACK:
                    begin
                        if (is_full)
                        begin
                            status_next = deqpm_pkg::STAT_FULL;
                        end
                        else
                        begin
                            for (int i = 0; i < CAPACITY; i++)
                            begin
                                if (CW'(i) == count_reg)
                                begin
                                    cell_op[i] = deqpm_pkg::OP_LOAD;
                                end
                            end
                            count_next = count_reg + CW'(1);
                        end
                    end

                    deqpm_pkg::CMD_PUSH_FRONT:
                    begin
                        if (is_full)
                        begin
                            status_next = deqpm_pkg::STAT_FULL;
                        end
                        else
                        begin
                            cell_op[0] = deqpm_pkg::OP_LOAD;
                            for (int i = 1; i < CAPACITY; i++)
                            begin
                                cell_op[i] = deqpm_pkg::OP_FROM_LEFT;
                            end
                            count_next = count_reg + CW'(1);
                        end
                    end

                    deqpm_pkg::CMD_POP_BACK:
                    begin
                        if (is_empty_now)
                        begin
                            status_next = deqpm_pkg::STAT_EMPTY;
                        end
                        else
                        begin
                            popped_next = back_val;
                            count_next  = count_reg - CW'(1);
                        end
                    end

                    deqpm_pkg::CMD_POP_FRONT:
                    begin
                        if (is_empty_now)
                        begin
                            status_next = deqpm_pkg::STAT_EMPTY;
                        end
                        else
                        begin
                            popped_next = cell_val[0];
                            for (int i = 0; i < CAPACITY; i++)
                            begin
                                cell_op[i] = deqpm_pkg::OP_FROM_RIGHT;
                            end
                            count_next = count_reg - CW'(1);
                        end
                    end

                    deqpm_pkg::CMD_POP_MAX:
                    begin
                        if (is_empty_now)
                        begin
                            status_next = deqpm_pkg::STAT_EMPTY;
                        end
                        else
                        begin
                            scan_cnt_next = '0;
                            state_next    = deqpm_pkg::ST_SCAN;
                        end
                    end

                    default:
                    begin
                    end
                endcase
            end

            // The cells are unchanged here, so at the end of the scan the last
            // cell of the chain holds the maximum and its position.
            deqpm_pkg::ST_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + IW'(1);
                if (scan_cnt_reg == IW'(CAPACITY - 1))
                begin
                    best_next   = idx_bus[CAPACITY-1];
                    popped_next = scan_bus[CAPACITY-1].value;
                    state_next  = deqpm_pkg::ST_REMOVE;
                end
            end

            // Elements behind the removed one move one place toward the front.
            deqpm_pkg::ST_REMOVE:
            begin
                for (int i = 0; i < CAPACITY; i++)
                begin
                    if ((IW'(i) >= best_reg) && (CW'(i + 1) < count_reg))
                    begin
                        cell_op[i] = deqpm_pkg::OP_FROM_RIGHT;
                    end
                end
                count_next = count_reg - CW'(1);
                state_next = deqpm_pkg::ST_REPORT;
            end

            deqpm_pkg::ST_REPORT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    load_out   = 1'b1;
                    state_next = deqpm_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = deqpm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= deqpm_pkg::ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // The occupancy field is the low bits of the count, zero-extended if narrower.
    assign occ_wide = 32'(count_reg);

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cmd_reg <= s_tdata[deqpm_pkg::CMD_W-1:0];
            val_reg <= $signed(s_tdata[deqpm_pkg::CMD_W +: DW]);
        end
        scan_cnt_reg <= scan_cnt_next;
        best_reg     <= best_next;
        popped_reg   <= popped_next;
        status_reg   <= status_next;
        if (load_out)
        begin
            m_tdata_reg <= {occ_wide[deqpm_pkg::OCC_W-1:0], back_val, front_val,
                            is_empty_now, popped_reg, status_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== hdl/deqpm_checker.sv =====
// Port-level checker for the double-ended queue with pop-maximum, bound to the top level.
`timescale 1ns / 1ps

module deqpm_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [deqpm_pkg::M_TDATA_W-1:0]   m_tdata
);

    logic [1:0]  r_status;
    logic [31:0] r_popped;
    logic        r_empty;
    logic [31:0] r_front;
    logic [31:0] r_back;
    logic [4:0]  r_occ;

    assign r_status = m_tdata[1:0];
    assign r_popped = m_tdata[33:2];
    assign r_empty  = m_tdata[34];
    assign r_front  = m_tdata[66:35];
    assign r_back   = m_tdata[98:67];
    assign r_occ    = m_tdata[103:99];

    // A stalled result must hold.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (r_empty == (r_occ == 5'd0)))
        else $error("empty flag disagrees with occupancy");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (r_status == deqpm_pkg::STAT_DONE || r_status == deqpm_pkg::STAT_EMPTY
                      || r_status == deqpm_pkg::STAT_FULL))
        else $error("undefined status code");

    a_fail_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (r_status != deqpm_pkg::STAT_DONE) |-> (r_popped == 32'd0))
        else $error("failed command reports a popped value");

    a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && r_empty |-> (r_front == 32'd0) && (r_back == 32'd0))
        else $error("empty queue reports nonzero front or back");

endmodule

bind double_ended_queue_with_pop_max deqpm_checker u_deqpm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/deqpm_result_checker.sv =====
// Result checker for the double-ended queue: predicts every result and compares it.
`timescale 1ns / 1ps

module deqpm_result_checker #(
    parameter int CAPACITY = deqpm_pkg::CAPACITY_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [deqpm_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [deqpm_pkg::M_TDATA_W-1:0]   m_tdata,
    output int                                fail_count,
    output int                                pending_count
);

    import deqpm_pkg::*;

    // Command layout, lowest field last.
    typedef struct packed {
        logic [S_TDATA_W-CMD_W-DATA_W-1:0] pad;
        logic [DATA_W-1:0]                 value;
        logic [CMD_W-1:0]                  op;
    } command_t;

    // Result layout, lowest field last.
    typedef struct packed {
        logic [OCC_W-1:0]    occupancy;
        logic [DATA_W-1:0]   back_value;
        logic [DATA_W-1:0]   front_value;
        logic                is_empty;
        logic [DATA_W-1:0]   popped_value;
        logic [STATUS_W-1:0] status;
    } report_t;

    logic [DATA_W-1:0] contents[$];
    report_t           expected_reports[$];
    report_t           want;
    report_t           got;
    command_t          cmd_in;
    int                errors = 0;
    int                outstanding = 0;

    assign fail_count    = errors;
    assign pending_count = outstanding;

    // Applies one command to the predicted queue and returns the report it should give.
    function automatic report_t run_queue_command(logic [CMD_W-1:0] op,
                                                  logic [DATA_W-1:0] value);
        report_t rep;
        int      best;
        rep = '0;
        rep.status = STAT_DONE;
        case (op)
            CMD_PUSH_BACK, CMD_PUSH_FRONT:
            begin
                if (contents.size() >= CAPACITY)
                    rep.status = STAT_FULL;
                else if (op == CMD_PUSH_BACK)
                    contents.push_back(value);
                else
                    contents.push_front(value);
            end
            CMD_POP_BACK, CMD_POP_FRONT, CMD_POP_MAX:
            begin
                if (contents.size() == 0)
                    rep.status = STAT_EMPTY;
                else if (op == CMD_POP_BACK)
                    rep.popped_value = contents.pop_back();
                else if (op == CMD_POP_FRONT)
                    rep.popped_value = contents.pop_front();
                else
                begin
                    // Strict compare keeps the tied maximum nearest the front.
                    best = 0;
                    for (int i = 1; i < contents.size(); i++)
                        if ($signed(contents[i]) > $signed(contents[best]))
                            best = i;
                    rep.popped_value = contents[best];
                    contents.delete(best);
                end
            end
            default:
            begin
            end
        endcase
        rep.is_empty = (contents.size() == 0);
        if (!rep.is_empty)
        begin
            rep.front_value = contents[0];
            rep.back_value  = contents[$];
        end
        rep.occupancy = OCC_W'(contents.size());
        return rep;
    endfunction

    task automatic compare_field(input string name, input logic [DATA_W-1:0] exp_val,
                                 input logic [DATA_W-1:0] act_val);
        if (act_val !== exp_val)
        begin
            errors++;
            $error("%s mismatch: expected %0h, actual %0h", name, exp_val, act_val);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // Results at this edge always belong to earlier commands, so compare first.
            if (m_tvalid && m_tready)
            begin
                got = report_t'(m_tdata);
                if (expected_reports.size() == 0)
                begin
                    errors++;
                    $error("result transfer with no command outstanding");
                end
                else
                begin
                    want = expected_reports.pop_front();
                    compare_field("status", DATA_W'(want.status), DATA_W'(got.status));
                    compare_field("popped_value", want.popped_value, got.popped_value);
                    compare_field("is_empty", DATA_W'(want.is_empty),
                                  DATA_W'(got.is_empty));
                    compare_field("front_value", want.front_value, got.front_value);
                    compare_field("back_value", want.back_value, got.back_value);
                    compare_field("occupancy", DATA_W'(want.occupancy),
                                  DATA_W'(got.occupancy));
                end
            end
            if (s_tvalid && s_tready)
            begin
                cmd_in = command_t'(s_tdata);
                expected_reports.push_back(run_queue_command(cmd_in.op, cmd_in.value));
            end
            outstanding = expected_reports.size();
        end
    end

endmodule

// ===== tb/tb_double_ended_queue_with_pop_max.sv =====
// Testbench top for the double-ended queue with pop-maximum: stimulus, flow control, verdict.
`timescale 1ns / 1ps

module tb_double_ended_queue_with_pop_max;

    import deqpm_pkg::*;

    localparam int CAPACITY = CAPACITY_DEF;

    // Least number of random commands in the mixed rounds after the opening push round.
    localparam int RANDOM_ITEMS = 480;

    // Pop maximum is the slowest command; after the last result we let twice
    // its run time pass so that a stray extra result would show up.
    localparam int DRAIN_CYCLES = 2 * (CAPACITY + 3);

    // The slowest correct run is roughly 500 commands, each with a sender gap,
    // a pop maximum and a receiver stall, plus one long hold-off. The limit
    // below leaves a wide margin on top of that.
    localparam int CYCLE_LIMIT = 200000;

    // Long receiver hold-off so that the output register fills and the
    // block has to stall its input while commands keep being offered.
    localparam int HOLD_AT     = 150;
    localparam int HOLD_CYCLES = 400;

    // Every third stretch of this many transfers runs with no idling on one side.
    localparam int STRETCH = 40;

    localparam logic [CMD_W-1:0]  CMD_UNUSED_LO = 3'd5;
    localparam logic [CMD_W-1:0]  CMD_UNUSED_HI = 3'd7;
    localparam logic [DATA_W-1:0] VAL_MAX       = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] VAL_MIN       = 32'h8000_0000;
    localparam logic [DATA_W-1:0] VAL_ONES      = 32'hFFFF_FFFF;

    // Traffic shapes for the random part. Fill and drain push the queue to its
    // full and empty edges, tie mode uses a narrow value range so that pop
    // maximum keeps meeting equal maxima.
    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIX,
        MODE_TIES
    } traffic_mode_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;

    int fail_count;
    int pending_count;
    int sent_count     = 0;
    int received_count = 0;
    int cycle_count    = 0;

    double_ended_queue_with_pop_max #(
        .CAPACITY (CAPACITY)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // The checker watches both channels, predicts each result and compares.
    deqpm_result_checker #(
        .CAPACITY (CAPACITY)
    ) checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Offers one command and returns once its transfer has happened. Inputs
    // change only at the falling edge; the handshake is sampled at the rising
    // edge. Valid stays high across back-to-back commands, so it is written
    // once per falling edge at most.
    task automatic send_cmd(input logic [CMD_W-1:0] op, input logic [DATA_W-1:0] value);
        int gap;
        gap = (((sent_count / STRETCH) % 3) == 1) ? 0 : $urandom_range(0, 13);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  = {{(S_TDATA_W - DATA_W - CMD_W){1'b0}}, value, op};
        s_tvalid = 1'b1;
        do @(posedge clk); while (!s_tready);
        sent_count++;
    endtask

    // Picks a command code for the given traffic shape. A small share of the
    // codes are unused ones, which must leave the queue untouched.
    function automatic logic [CMD_W-1:0] pick_command(traffic_mode_t mode);
        int roll;
        int push_pct;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            return CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        case (mode)
            MODE_FILL:  push_pct = 85;
            MODE_DRAIN: push_pct = 12;
            MODE_TIES:  push_pct = 55;
            default:    push_pct = 50;
        endcase
        if ($urandom_range(0, 99) < push_pct)
            return $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
        roll = $urandom_range(0, 99);
        if (mode == MODE_TIES || roll < 40)
            return CMD_POP_MAX;
        return (roll < 70) ? CMD_POP_BACK : CMD_POP_FRONT;
    endfunction

    // Values are mostly full-range random, with a share of extremes and a
    // share clustered around zero so that equal values are common.
    function automatic logic [DATA_W-1:0] pick_value(bit narrow);
        int roll;
        roll = $urandom_range(0, 99);
        if (narrow || roll < 15)
            return $urandom_range(0, 6) - 3;
        if (roll < 25)
        begin
            case ($urandom_range(0, 3))
                0:       return VAL_MAX;
                1:       return VAL_MIN;
                2:       return '0;
                default: return VAL_ONES;
            endcase
        end
        return $urandom();
    endfunction

    // Sender: reset, directed commands, then random rounds of traffic.
    initial
    begin
        traffic_mode_t mode;
        int            round_len;
        int            items;

        s_tvalid = 1'b0;
        s_tdata  = '0;
        rst_n    = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Every kind of pop on an empty queue reports empty status.
        send_cmd(CMD_POP_BACK, '0);
        send_cmd(CMD_POP_FRONT, VAL_ONES);
        send_cmd(CMD_POP_MAX, '0);

        // Unused codes on an empty queue.
        send_cmd(CMD_UNUSED_LO, VAL_ONES);
        send_cmd(CMD_UNUSED_LO + 3'd1, VAL_MAX);
        send_cmd(CMD_UNUSED_HI, VAL_MIN);

        // Build 5, -1, MIN, MAX, 0, MAX: two equal maxima with other values between.
        send_cmd(CMD_PUSH_BACK, VAL_MAX);
        send_cmd(CMD_PUSH_FRONT, VAL_MIN);
        send_cmd(CMD_PUSH_BACK, '0);
        send_cmd(CMD_PUSH_FRONT, VAL_ONES);
        send_cmd(CMD_PUSH_BACK, VAL_MAX);
        send_cmd(CMD_PUSH_FRONT, 32'd5);

        // The first pop maximum must take the maximum nearer the front.
        send_cmd(CMD_POP_MAX, '0);
        send_cmd(CMD_POP_MAX, '0);

        // An unused code on a non-empty queue still reports its contents.
        send_cmd(CMD_UNUSED_LO + 3'd1, VAL_ONES);

        // Empty the queue from both ends and through pop maximum, down to a
        // single element and past it.
        send_cmd(CMD_POP_FRONT, '0);
        send_cmd(CMD_POP_BACK, '0);
        send_cmd(CMD_POP_MAX, '0);
        send_cmd(CMD_POP_MAX, '0);
        send_cmd(CMD_POP_MAX, '0);

        // Opening random round: pushes only, enough to fill the queue and
        // then hit it twice while full.
        repeat (CAPACITY + 2)
            send_cmd($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK,
                     pick_value(1'b0));

        items = 0;
        while (items < RANDOM_ITEMS)
        begin
            mode      = traffic_mode_t'($urandom_range(0, 3));
            round_len = $urandom_range(8, 40);
            repeat (round_len)
            begin
                send_cmd(pick_command(mode), pick_value(mode == MODE_TIES));
                items++;
            end
        end

        @(negedge clk);
        s_tvalid = 1'b0;

        wait (pending_count == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        // Step off the rising edge so the checker's last updates have settled.
        @(negedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Receiver: a random stall before each result transfer, stretches with no
    // stalls, and one long hold-off that backs the block up into its input.
    initial
    begin
        int gap;
        m_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            if (received_count == HOLD_AT)
                gap = HOLD_CYCLES;
            else if (((received_count / STRETCH) % 3) == 2)
                gap = 0;
            else
                gap = $urandom_range(0, 13);
            if (gap > 0)
            begin
                @(negedge clk);
                m_tready = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            m_tready = 1'b1;
            do @(posedge clk); while (!m_tvalid);
            received_count++;
        end
    end

endmodule
